// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL controller (fol_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FOL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frequency ordered list: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frequency ordered list: next-cycle check failed");

`endif

// ===== sv/fol_pkg.sv =====
`default_nettype none
package fol_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 16;

    localparam int IDX_W = $clog2(ENTRIES);

    // Port field widths.
    localparam int KEY_W   = 16;
    localparam int POS_W   = 4;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 16;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POS_RD,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_MOVE_RD,
        ST_MOVE_CMP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_POS,
        RD_PREV
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_MISS,
        RES_READ,
        RES_OOR,
        RES_HIT
    } res_sel_t;

    typedef struct packed {
        logic     ready;
        logic     load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     idx_clr;
        logic     idx_inc;
        logic     hit_cap;
        logic     wr_shift;
        logic     wr_final;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic req_valid;
        logic is_read;
        logic pos_ok;
        logic key_match;
        logic idx_last;
        logic j_zero;
        logic move_more;
        logic out_free;
    } st_t;

    // Key held by a slot that has not been written since reset.
    function automatic logic [KEY_BITS-1:0] reset_key(input logic [IDX_W-1:0] idx);
        logic [31:0] t;
        t = 32'(idx) + 32'd1;
        return t[KEY_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/fol_if.sv =====
`default_nettype none
interface fol_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [fol_pkg::KEY_W-1:0]    key;
    logic [fol_pkg::POS_W-1:0]    position;

    modport source (output valid, operation, key, position, input ready);
    modport sink (input valid, operation, key, position, output ready);
endinterface

interface fol_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [fol_pkg::SLOT_W-1:0]   slot;
    logic [fol_pkg::KEY_W-1:0]    entry_key;
    logic [fol_pkg::COUNT_W-1:0]  count;

    modport source (output valid, found, slot, entry_key, count, input ready);
    modport sink (input valid, found, slot, entry_key, count, output ready);
endinterface
`default_nettype wire

// ===== sv/fol_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module fol_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fol_pkg::st_t  st,
    output fol_pkg::cmd_t      cmd
);

    fol_pkg::state_t state_reg;
    fol_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fol_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            fol_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (st.req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = fol_pkg::ST_DECODE;
                end
            end
            fol_pkg::ST_DECODE:
            begin
                if (st.is_read)
                begin
                    if (st.pos_ok)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = fol_pkg::RD_POS;
                        state_next = fol_pkg::ST_POS_RD;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = fol_pkg::RES_OOR;
                        state_next   = fol_pkg::ST_EMIT;
                    end
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = fol_pkg::ST_SRCH_RD;
                end
            end
            fol_pkg::ST_POS_RD:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = fol_pkg::RES_READ;
                state_next   = fol_pkg::ST_EMIT;
            end
            fol_pkg::ST_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = fol_pkg::RD_IDX;
                state_next = fol_pkg::ST_SRCH_CMP;
            end
            fol_pkg::ST_SRCH_CMP:
            begin
                if (st.key_match)
                begin
                    cmd.hit_cap = 1'b1;
                    state_next  = fol_pkg::ST_MOVE_RD;
                end
                else if (st.idx_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = fol_pkg::RES_MISS;
                    state_next   = fol_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = fol_pkg::ST_SRCH_RD;
                end
            end
            fol_pkg::ST_MOVE_RD:
            begin
                if (st.j_zero)
                begin
                    cmd.wr_final = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = fol_pkg::RES_HIT;
                    state_next   = fol_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = fol_pkg::RD_PREV;
                    state_next = fol_pkg::ST_MOVE_CMP;
                end
            end
            fol_pkg::ST_MOVE_CMP:
            begin
                // The entry ahead has a smaller count: it slides back one slot.
                if (st.move_more)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = fol_pkg::ST_MOVE_RD;
                end
                else
                begin
                    cmd.wr_final = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = fol_pkg::RES_HIT;
                    state_next   = fol_pkg::ST_EMIT;
                end
            end
            fol_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fol_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fol_pkg::ST_IDLE;
            end
        endcase
    end

    `FOL_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, st.out_free)
    `FOL_ASSERT_SAME(a_shift_not_front, clk, rst_n, cmd.wr_shift, !st.j_zero)
    `FOL_ASSERT_SAME(a_final_with_result, clk, rst_n, cmd.wr_final,
                     cmd.res_load && cmd.res_sel == fol_pkg::RES_HIT)
    `FOL_ASSERT_NEXT(a_miss_to_emit, clk, rst_n,
                     state_reg == fol_pkg::ST_SRCH_CMP && !st.key_match && st.idx_last,
                     state_reg == fol_pkg::ST_EMIT)

endmodule
`default_nettype wire

// ===== sv/fol_dpath.sv =====
`default_nettype none
module fol_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fol_req_if.sink            req,
    fol_rsp_if.source          rsp,
    input  wire fol_pkg::cmd_t cmd,
    output fol_pkg::st_t       st
);

    localparam int IW = fol_pkg::IDX_W;
    localparam int KB = fol_pkg::KEY_BITS;
    localparam int CB = fol_pkg::COUNT_BITS;

    // Table storage; a slot without its valid bit reads as its reset value.
    logic [KB-1:0]               key_mem_reg [fol_pkg::ENTRIES];
    logic [CB-1:0]               cnt_mem_reg [fol_pkg::ENTRIES];
    logic [fol_pkg::ENTRIES-1:0] vld_reg;

    logic [KB-1:0] rd_key_reg;
    logic [CB-1:0] rd_cnt_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_addr_reg;

    logic                      op_reg;
    logic [KB-1:0]             key_reg;
    logic [fol_pkg::POS_W-1:0] pos_reg;

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] j_reg;
    logic [KB-1:0] hk_reg;
    logic [CB-1:0] hc_reg;

    logic                        res_found_reg;
    logic [fol_pkg::SLOT_W-1:0]  res_slot_reg;
    logic [fol_pkg::KEY_W-1:0]   res_key_reg;
    logic [fol_pkg::COUNT_W-1:0] res_cnt_reg;

    logic                        rsp_valid_reg;
    logic                        rsp_found_reg;
    logic [fol_pkg::SLOT_W-1:0]  rsp_slot_reg;
    logic [fol_pkg::KEY_W-1:0]   rsp_key_reg;
    logic [fol_pkg::COUNT_W-1:0] rsp_cnt_reg;

    logic [IW-1:0] rd_addr;
    logic [KB-1:0] rd_key;
    logic [CB-1:0] rd_cnt;
    logic [CB-1:0] cnt_inc;
    logic          wr_en;
    logic [KB-1:0] wr_key;
    logic [CB-1:0] wr_cnt;

    always_comb
    begin
        case (cmd.rd_sel)
            fol_pkg::RD_POS:  rd_addr = IW'(pos_reg);
            fol_pkg::RD_PREV: rd_addr = j_reg - 1'b1;
            default:          rd_addr = idx_reg;
        endcase
    end

    assign rd_key  = rd_vld_reg ? rd_key_reg : fol_pkg::reset_key(rd_addr_reg);
    assign rd_cnt  = rd_vld_reg ? rd_cnt_reg : '0;
    assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

    assign wr_en  = cmd.wr_shift | cmd.wr_final;
    assign wr_key = cmd.wr_shift ? rd_key : hk_reg;
    assign wr_cnt = cmd.wr_shift ? rd_cnt : hc_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem_reg[j_reg] <= wr_key;
            cnt_mem_reg[j_reg] <= wr_cnt;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg  <= key_mem_reg[rd_addr];
            rd_cnt_reg  <= cnt_mem_reg[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[j_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.operation;
            key_reg <= KB'(req.key);
            pos_reg <= req.position;
        end
        if (cmd.hit_cap)
        begin
            hk_reg <= rd_key;
            hc_reg <= cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            j_reg   <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.hit_cap)
            begin
                j_reg <= rd_addr_reg;
            end
            else if (cmd.wr_shift)
            begin
                j_reg <= j_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                fol_pkg::RES_READ:
                begin
                    res_found_reg <= 1'b1;
                    res_slot_reg  <= pos_reg;
                    res_key_reg   <= fol_pkg::KEY_W'(rd_key);
                    res_cnt_reg   <= fol_pkg::COUNT_W'(rd_cnt);
                end
                fol_pkg::RES_OOR:
                begin
                    res_found_reg <= 1'b0;
                    res_slot_reg  <= pos_reg;
                    res_key_reg   <= '0;
                    res_cnt_reg   <= '0;
                end
                fol_pkg::RES_HIT:
                begin
                    res_found_reg <= 1'b1;
                    res_slot_reg  <= fol_pkg::SLOT_W'(j_reg);
                    res_key_reg   <= fol_pkg::KEY_W'(hk_reg);
                    res_cnt_reg   <= fol_pkg::COUNT_W'(hc_reg);
                end
                default:
                begin
                    res_found_reg <= 1'b0;
                    res_slot_reg  <= '0;
                    res_key_reg   <= '0;
                    res_cnt_reg   <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_found_reg <= res_found_reg;
            rsp_slot_reg  <= res_slot_reg;
            rsp_key_reg   <= res_key_reg;
            rsp_cnt_reg   <= res_cnt_reg;
        end
    end

    assign req.ready     = cmd.ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = rsp_found_reg;
    assign rsp.slot      = rsp_slot_reg;
    assign rsp.entry_key = rsp_key_reg;
    assign rsp.count     = rsp_cnt_reg;

    assign st.req_valid = req.valid;
    assign st.is_read   = (op_reg == fol_pkg::OP_READ);
    assign st.pos_ok    = (32'(pos_reg) < fol_pkg::ENTRIES);
    assign st.key_match = (rd_key == key_reg);
    assign st.idx_last  = (idx_reg == IW'(fol_pkg::ENTRIES - 1));
    assign st.j_zero    = (j_reg == '0);
    assign st.move_more = (rd_cnt < hc_reg);
    assign st.out_free  = !rsp_valid_reg || rsp.ready;

endmodule
`default_nettype wire

// ===== sv/frequency_ordered_list_core.sv =====
`default_nettype none
// Frequency-ordered key table: ENTRIES slots of key and access count, kept in
// non-increasing count order. An access scans the table from slot 0, reading and
// then comparing one slot at a time, since the table sits in a memory with one
// registered read port; on a hit the count rises (saturating) and the entry
// slides forward past every entry with a smaller count, one slot per move.
// One item is worked on at a time; the response register lets the next item in
// while a result waits.
module frequency_ordered_list_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fol_req_if.sink    req,
    fol_rsp_if.source  rsp
);

    fol_pkg::cmd_t cmd;
    fol_pkg::st_t  st;

    fol_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    fol_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .st    (st)
    );

endmodule
`default_nettype wire

// ===== sim/tb_frequency_ordered_list_core.sv =====
`timescale 1ns / 100ps
module tb_frequency_ordered_list_core;

    localparam int CYCLE_LIMIT   = 5000000;
    localparam int PHASE_ITEMS   = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOT_HITS      = 60;
    localparam int NUM_DIRECTED  = 23;

    localparam logic [fol_pkg::COUNT_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic                        found;
        logic [fol_pkg::SLOT_W-1:0]  slot;
        logic [fol_pkg::KEY_W-1:0]   entry_key;
        logic [fol_pkg::COUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic                      op;
        logic [fol_pkg::KEY_W-1:0] key;
        logic [fol_pkg::POS_W-1:0] pos;
        logic                      typed;
        result_t                   res;
    } dir_row_t;

    // Rows marked typed carry their expected result; the rest use the table model.
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{fol_pkg::OP_READ,   16'h0000, 4'd0,  1'b1, '{1'b1, 4'd0,  16'd1,  16'd0}},
        '{fol_pkg::OP_READ,   16'hffff, 4'd15, 1'b1, '{1'b1, 4'd15, 16'd16, 16'd0}},
        '{fol_pkg::OP_ACCESS, 16'h0000, 4'd15, 1'b1, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'hffff, 4'd0,  1'b1, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd16,   4'd0,  1'b1, '{1'b1, 4'd0,  16'd16, 16'd1}},
        '{fol_pkg::OP_READ,   16'h0000, 4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_READ,   16'h0000, 4'd1,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd16,   4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd1,    4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd1,    4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd1,    4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_READ,   16'h0000, 4'd1,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd8,    4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'h8000, 4'd0,  1'b1, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'h5555, 4'd5,  1'b1, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'haaaa, 4'd10, 1'b1, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_READ,   16'h0000, 4'd15, 1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd15,   4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd2,    4'd15, 1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd9,    4'd7,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_READ,   16'h1234, 4'd5,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_READ,   16'hffff, 4'd10, 1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}},
        '{fol_pkg::OP_ACCESS, 16'd16,   4'd0,  1'b0, '{1'b0, 4'd0,  16'd0,  16'd0}}
    };

    logic clk;
    logic rst_n;

    fol_req_if req_if ();
    fol_rsp_if rsp_if ();

    frequency_ordered_list_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [fol_pkg::KEY_W-1:0]   tbl_key [fol_pkg::ENTRIES];
    logic [fol_pkg::COUNT_W-1:0] tbl_cnt [fol_pkg::ENTRIES];

    result_t pending_results [$];
    result_t arrived_want;
    int      mismatches;
    int      cycle_count;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    bit      hold_off_req;

    always #10 clk = ~clk;

    // Applies one transfer to the local copy of the table and returns its result.
    function automatic result_t apply_item(input logic op,
                                           input logic [fol_pkg::KEY_W-1:0] k,
                                           input logic [fol_pkg::POS_W-1:0] p);
        result_t                     r;
        int                          i;
        int                          hit;
        int                          j;
        logic [fol_pkg::KEY_W-1:0]   hk;
        logic [fol_pkg::COUNT_W-1:0] hc;
        r = '0;
        if (op == fol_pkg::OP_READ)
        begin
            r.slot = p;
            if (int'(p) < fol_pkg::ENTRIES)
            begin
                r.found     = 1'b1;
                r.entry_key = tbl_key[p];
                r.count     = tbl_cnt[p];
            end
            return r;
        end
        hit = -1;
        for (i = 0; i < fol_pkg::ENTRIES; i++)
        begin
            if (hit < 0 && tbl_key[i] == k)
                hit = i;
        end
        if (hit < 0)
            return r;
        hk = tbl_key[hit];
        hc = tbl_cnt[hit];
        if (hc != COUNT_SAT)
            hc = hc + 1'b1;
        // Slide forward past strictly smaller counts; equal counts keep their order.
        j = hit;
        while (j > 0 && tbl_cnt[j-1] < hc)
        begin
            tbl_key[j] = tbl_key[j-1];
            tbl_cnt[j] = tbl_cnt[j-1];
            j--;
        end
        tbl_key[j]  = hk;
        tbl_cnt[j]  = hc;
        r.found     = 1'b1;
        r.slot      = fol_pkg::SLOT_W'(j);
        r.entry_key = hk;
        r.count     = hc;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_item(input logic op, input logic [fol_pkg::KEY_W-1:0] k,
                             input logic [fol_pkg::POS_W-1:0] p, input logic typed,
                             input result_t typed_res);
        result_t predicted;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= k;
        req_if.position  <= p;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = apply_item(op, k, p);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            send_item(fol_pkg::OP_READ, fol_pkg::KEY_W'($urandom),
                      fol_pkg::POS_W'($urandom_range(15)), 1'b0, '0);
        else if (sel < 40)
            send_item(fol_pkg::OP_ACCESS, fol_pkg::KEY_W'($urandom),
                      fol_pkg::POS_W'($urandom), 1'b0, '0);
        else if (sel < 75)
            // A few hot keys build up distinct counts so entries reorder deeply.
            send_item(fol_pkg::OP_ACCESS, fol_pkg::KEY_W'($urandom_range(4, 1)),
                      fol_pkg::POS_W'($urandom), 1'b0, '0);
        else
            send_item(fol_pkg::OP_ACCESS, fol_pkg::KEY_W'($urandom_range(16, 1)),
                      fol_pkg::POS_W'($urandom), 1'b0, '0);
    endtask

    // Stops offering and waits until every pending result has arrived.
    task automatic drain();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h",
                         $time, rsp_if.found, rsp_if.slot, rsp_if.entry_key, rsp_if.count);
                mismatches++;
            end
            else
            begin
                arrived_want = pending_results.pop_front();
                check_field("found", 32'(arrived_want.found), 32'(rsp_if.found));
                check_field("slot", 32'(arrived_want.slot), 32'(rsp_if.slot));
                check_field("entry_key", 32'(arrived_want.entry_key),
                            32'(rsp_if.entry_key));
                check_field("count", 32'(arrived_want.count), 32'(rsp_if.count));
            end
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial
    begin
        int i;
        int ph;
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = fol_pkg::OP_ACCESS;
        req_if.key       = '0;
        req_if.position  = '0;
        mismatches       = 0;
        cycle_count      = 0;
        snd_idle_pct     = 0;
        rcv_idle_pct     = 0;
        hold_off_req     = 1'b0;
        for (i = 0; i < fol_pkg::ENTRIES; i++)
        begin
            tbl_key[i] = fol_pkg::KEY_W'(i + 1);
            tbl_cnt[i] = '0;
        end

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pos,
                      directed_rows[i].typed, directed_rows[i].res);
        drain();

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    snd_idle_pct = 14;
                    rcv_idle_pct = 87;
                end
                1:
                begin
                    snd_idle_pct = 87;
                    rcv_idle_pct = 14;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    // The sender keeps pushing while results back up behind the hold-off.
                    hold_off_req = 1'b1;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
                send_random();
            drain();
        end

        // Hammer one key so its count climbs far above the rest, then mix traffic in.
        for (i = 0; i < HOT_HITS; i++)
            send_item(fol_pkg::OP_ACCESS, fol_pkg::KEY_W'(7), fol_pkg::POS_W'($urandom),
                      1'b0, '0);
        send_item(fol_pkg::OP_READ, fol_pkg::KEY_W'($urandom), fol_pkg::POS_W'(0),
                  1'b0, '0);
        for (i = 0; i < 20; i++)
            send_random();
        drain();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fol_pkg.sv
sv/fol_if.sv
sv/fol_ctrl.sv
sv/fol_dpath.sv
sv/frequency_ordered_list_core.sv
sim/tb_frequency_ordered_list_core.sv
